// ===== hw/rtl/gdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Gregorian date difference: shared package
// Field widths, day-number constants, the month offset table and the beat
// that a day-number lane hands to the merging stage.
// ----------------------------------------------------------------------------
package gdd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DIFF_W   = 23;

    // A 14-bit year gives at most 366 * 16384 + 456 days, which fits 23 bits.
    localparam int DAYNUM_W = 23;

    localparam int YEAR_MAX_DEFAULT = 9999;

    // Reciprocal of 100: ceil(2^20 / 100). Exact for every 14-bit year.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 14;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(10486);

    // Year divided by 100 stays below 164.
    localparam int CENT_W = 8;

    localparam int MDAYS_W = 9;
    localparam logic [MONTH_W-1:0] MONTH_MARCH = MONTH_W'(3);

    typedef struct packed {
        logic                valid;
        logic [DAYNUM_W-1:0] daynum;
    } lane_out_t;

    // Days before the first of a month in a common year. Months past
    // December continue as months of 30 days.
    function automatic logic [MDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [MDAYS_W-1:0] d;
        begin
            unique case (m)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd0;
                4'd2:    d = 9'd31;
                4'd3:    d = 9'd59;
                4'd4:    d = 9'd90;
                4'd5:    d = 9'd120;
                4'd6:    d = 9'd151;
                4'd7:    d = 9'd181;
                4'd8:    d = 9'd212;
                4'd9:    d = 9'd243;
                4'd10:   d = 9'd273;
                4'd11:   d = 9'd304;
                4'd12:   d = 9'd334;
                4'd13:   d = 9'd365;
                4'd14:   d = 9'd395;
                4'd15:   d = 9'd425;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

// ===== hw/rtl/gregorian_date_difference.sv =====
// ----------------------------------------------------------------------------
// Gregorian date difference
// Signed number of days from a first to a second proleptic Gregorian date.
// ----------------------------------------------------------------------------
// Usage:
//   A beat of two dates is taken at each rising edge where start is high and
//   busy is low. busy never rises, so a new beat may come every cycle.
//   Each date goes to its own day-number lane. A lane is three registered
//   stages: year saturation and a multiply by the reciprocal of 100, then
//   the century split with 365 * year, the leap-year terms and the month
//   offset, then the final sum. The merging stage subtracts the two day
//   numbers and registers the result.
//   The result of a beat passes the three lane stages and the merging
//   register and is then on day_difference, with done high, for one cycle.
//   Throughput is one beat per cycle, set by the lane pipelines.
//   The receiver cannot stall; every result is shown exactly once.
//   Reset clears the valid bits of every stage, so nothing is in flight
//   afterwards; there is no memory and no clearing pass.
//   Years above YEAR_MAX count as YEAR_MAX, and dates are not checked: the
//   day adds linearly and months past December run on as 30-day months.
// ----------------------------------------------------------------------------
module gregorian_date_difference #(
    parameter int YEAR_MAX = gdd_pkg::YEAR_MAX_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [gdd_pkg::YEAR_W-1:0]        first_year,
    input  logic [gdd_pkg::MONTH_W-1:0]       first_month,
    input  logic [gdd_pkg::DAY_W-1:0]         first_day,
    input  logic [gdd_pkg::YEAR_W-1:0]        second_year,
    input  logic [gdd_pkg::MONTH_W-1:0]       second_month,
    input  logic [gdd_pkg::DAY_W-1:0]         second_day,
    output logic                              done,
    output logic signed [gdd_pkg::DIFF_W-1:0] day_difference
);

    gdd_pkg::lane_out_t first_num;
    gdd_pkg::lane_out_t second_num;
    logic               accept;

    // The pipeline never holds a beat back, so the block is never busy.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    gdd_lane #(
        .YEAR_MAX (YEAR_MAX)
    ) u_first_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .year     (first_year),
        .month    (first_month),
        .day      (first_day),
        .result   (first_num)
    );

    gdd_lane #(
        .YEAR_MAX (YEAR_MAX)
    ) u_second_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .year     (second_year),
        .month    (second_month),
        .day      (second_day),
        .result   (second_num)
    );

    gdd_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .first_num      (first_num),
        .second_num     (second_num),
        .done           (done),
        .day_difference (day_difference)
    );

`ifndef SYNTHESIS
    // A result only ever follows a matching earlier start beat.
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result strobe without a matching start beat");

    // Two equal dates are zero days apart.
    a_same_date_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(first_year, 4) == $past(second_year, 4))
              && ($past(first_month, 4) == $past(second_month, 4))
              && ($past(first_day, 4) == $past(second_day, 4)))
        |-> (day_difference == '0))
        else $error("equal dates gave a nonzero difference");

    // Moving only the second day forward by one adds one day to the result.
    // The day is widened by a bit so that day 31 never wraps to day 0.
    a_day_step_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(first_year, 4) == $past(second_year, 4))
              && ($past(first_month, 4) == $past(second_month, 4))
              && ({1'b0, $past(second_day, 4)} == {1'b0, $past(first_day, 4)} + 6'd1))
        |-> (day_difference == 23'sd1))
        else $error("one-day step did not give a difference of one");
`endif

endmodule

// ===== hw/rtl/gdd_lane.sv =====
// ----------------------------------------------------------------------------
// Gregorian date difference: day-number lane
// Three-stage pipeline that turns one date into its day number, counted so
// that 1 January of year 0 is day 1.
// ----------------------------------------------------------------------------
module gdd_lane #(
    parameter int YEAR_MAX = gdd_pkg::YEAR_MAX_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [gdd_pkg::YEAR_W-1:0]   year,
    input  logic [gdd_pkg::MONTH_W-1:0]  month,
    input  logic [gdd_pkg::DAY_W-1:0]    day,
    output gdd_pkg::lane_out_t           result
);

    localparam int YW = gdd_pkg::YEAR_W;
    localparam int NW = gdd_pkg::DAYNUM_W;
    localparam int CW = gdd_pkg::CENT_W;
    localparam int PW = YW + gdd_pkg::RECIP_W;
    localparam int YEAR_ALL_ONES = (1 << YW) - 1;
    localparam logic [YW-1:0] YEAR_CAP =
        (YEAR_MAX > YEAR_ALL_ONES) ? YW'(YEAR_ALL_ONES) : YW'(YEAR_MAX);

    // Stage 1: saturated year and its product with the reciprocal of 100.
    logic                               s1_valid_reg;
    logic [YW-1:0]                      s1_year_reg, s1_year_next;
    logic [PW-1:0]                      s1_prod_reg, s1_prod_next;
    logic [gdd_pkg::MONTH_W-1:0]        s1_month_reg;
    logic [gdd_pkg::DAY_W-1:0]          s1_day_reg;

    // Stage 2: the terms of the day number.
    logic                               s2_valid_reg;
    logic [NW-1:0]                      s2_base_reg, s2_base_next;
    logic [YW-1:0]                      s2_c4_reg, s2_c4_next;
    logic [CW-1:0]                      s2_c100_reg, s2_c100_next;
    logic [CW-3:0]                      s2_c400_reg, s2_c400_next;
    logic [gdd_pkg::MDAYS_W-1:0]        s2_mon_reg, s2_mon_next;
    logic [gdd_pkg::DAY_W-1:0]          s2_day_reg;

    // Stage 3: summed day number.
    logic                               s3_valid_reg;
    logic [NW-1:0]                      s3_num_reg, s3_num_next;

    logic [CW-1:0]                      cent;
    logic [YW-1:0]                      rem_full;
    logic                               rem_nz;
    logic                               leap;

    always_comb
    begin
        s1_year_next = (year > YEAR_CAP) ? YEAR_CAP : year;
        s1_prod_next = PW'(s1_year_next) * PW'(gdd_pkg::RECIP_100);
    end

    always_comb
    begin
        cent     = s1_prod_reg[gdd_pkg::RECIP_SHIFT +: CW];
        rem_full = s1_year_reg - (YW'(cent) * YW'(100));
        rem_nz   = (rem_full != '0);
        leap     = (s1_year_reg[1:0] == 2'b00) && (rem_nz || (cent[1:0] == 2'b00));

        // Leap years among 0 .. y-1: ceil(y/4) - ceil(y/100) + ceil(y/400).
        s2_base_next = NW'(s1_year_reg) * NW'(365);
        s2_c4_next   = {2'b00, s1_year_reg[YW-1:2]} + YW'(s1_year_reg[1:0] != 2'b00);
        s2_c100_next = cent + CW'(rem_nz);
        s2_c400_next = cent[CW-1:2] + (CW-2)'(rem_nz || (cent[1:0] != 2'b00));
        s2_mon_next  = gdd_pkg::days_before_month(s1_month_reg)
                     + gdd_pkg::MDAYS_W'(leap && (s1_month_reg >= gdd_pkg::MONTH_MARCH));
    end

    always_comb
    begin
        s3_num_next = s2_base_reg + NW'(s2_c4_reg) - NW'(s2_c100_reg) + NW'(s2_c400_reg)
                    + NW'(s2_mon_reg) + NW'(s2_day_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_year_reg  <= s1_year_next;
        s1_prod_reg  <= s1_prod_next;
        s1_month_reg <= month;
        s1_day_reg   <= day;
        s2_base_reg  <= s2_base_next;
        s2_c4_reg    <= s2_c4_next;
        s2_c100_reg  <= s2_c100_next;
        s2_c400_reg  <= s2_c400_next;
        s2_mon_reg   <= s2_mon_next;
        s2_day_reg   <= s1_day_reg;
        s3_num_reg   <= s3_num_next;
    end

    assign result.valid  = s3_valid_reg;
    assign result.daynum = s3_num_reg;

endmodule

// ===== hw/rtl/gdd_merge.sv =====
// ----------------------------------------------------------------------------
// Gregorian date difference: merging stage
// Subtracts the first lane's day number from the second's and registers the
// wrapped difference together with its strobe.
// ----------------------------------------------------------------------------
module gdd_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gdd_pkg::lane_out_t                first_num,
    input  gdd_pkg::lane_out_t                second_num,
    output logic                              done,
    output logic signed [gdd_pkg::DIFF_W-1:0] day_difference
);

    logic                          done_reg;
    logic [gdd_pkg::DIFF_W-1:0]    diff_reg, diff_next;

    always_comb
    begin
        diff_next = gdd_pkg::DIFF_W'(second_num.daynum - first_num.daynum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= second_num.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
    end

    assign done           = done_reg;
    assign day_difference = signed'(diff_reg);

`ifndef SYNTHESIS
    // Both lanes are fed by the same start beat, so they must stay in step.
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        first_num.valid == second_num.valid)
        else $error("day-number lanes out of step");
`endif

endmodule
